[design/extended_gcd_unit_defines.svh]
// Assertion macros shared by the extended gcd unit RTL.
// No dependencies.
`ifndef EXTENDED_GCD_UNIT_DEFINES_SVH
`define EXTENDED_GCD_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EGU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EGU_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EGU_ASSERT(label, clk, rst_n, prop, msg)
`define EGU_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[design/egu_pkg.sv]
// Package of the extended gcd unit: widths and controller/datapath command types.
// No dependencies.
package egu_pkg;
    localparam int unsigned DefWidth = 32;
    localparam int unsigned GcdW = 32;
    localparam int unsigned CoefW = 33;
    localparam int unsigned InDataW = 64;
    localparam int unsigned OutDataW = 104;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
    } t_egu_cmd;

    typedef struct packed {
        logic b_zero;
        logic div_last;
    } t_egu_status;
endpackage

[design/egu_ctrl.sv]
// Controller of the extended gcd unit: sequences load, division steps and updates.
// Depends on egu_pkg.
`include "extended_gcd_unit_defines.svh"
module egu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  egu_pkg::t_egu_status i_status,
    output egu_pkg::t_egu_cmd   o_cmd
);
    import egu_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_UPD, S_DONE} t_state;
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.b_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_CHECK;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    `EGU_ASSERT(a_no_both, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "ready and valid together")
    `EGU_ASSERT(a_load_idle, i_clk, i_rst_n, o_cmd.load |-> o_in_ready, "load outside idle")
    `EGU_ASSERT(a_done_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid, "result dropped")
endmodule

[design/egu_datapath.sv]
// Datapath of the extended gcd unit: remainder pair, restoring divider, coefficients.
// Depends on egu_pkg.
`include "extended_gcd_unit_defines.svh"
module egu_datapath #(
    parameter int unsigned WIDTH = egu_pkg::DefWidth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  egu_pkg::t_egu_cmd    i_cmd,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    output egu_pkg::t_egu_status o_status,
    output logic [WIDTH-1:0]     o_gcd,
    output logic [WIDTH:0]       o_x,
    output logic [WIDTH:0]       o_y
);
    import egu_pkg::*;

    localparam int unsigned CntW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_a, r_b, r_rem, r_dvd;
    logic [WIDTH:0]   r_cx, r_cy, r_nx, r_ny, r_mx, r_my;
    logic [CntW-1:0]  r_cnt;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_shift;
    logic             w_ge;

    assign w_shift = {r_rem, r_dvd[WIDTH-1]};
    assign w_trial = w_shift - {1'b0, r_b};
    assign w_ge = !w_trial[WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_a;
            r_b <= i_b;
            r_cx <= {{WIDTH{1'b0}}, 1'b1};
            r_cy <= '0;
            r_nx <= '0;
            r_ny <= {{WIDTH{1'b0}}, 1'b1};
        end
        if (i_cmd.div_start) begin
            r_dvd <= r_a;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= w_ge ? w_trial[WIDTH-1:0] : w_shift[WIDTH-1:0];
            r_cnt <= r_cnt + 1'b1;
            // Serial shift-add product q*new, accumulated MSB first.
            r_mx <= {r_mx[WIDTH-1:0], 1'b0} + (w_ge ? r_nx : '0);
            r_my <= {r_my[WIDTH-1:0], 1'b0} + (w_ge ? r_ny : '0);
        end else if (i_cmd.div_start) begin
            r_mx <= '0;
            r_my <= '0;
        end
        if (i_cmd.update) begin
            r_a <= r_b;
            r_b <= r_rem;
            r_cx <= r_nx;
            r_nx <= r_cx - r_mx;
            r_cy <= r_ny;
            r_ny <= r_cy - r_my;
        end
    end

    assign o_status.b_zero = (r_b == '0);
    assign o_status.div_last = (r_cnt == CntW'(WIDTH - 1));
    assign o_gcd = r_a;
    assign o_x = r_cx;
    assign o_y = r_cy;

    `EGU_ASSERT(a_rem_lt_b, i_clk, i_rst_n, i_cmd.update |-> (r_rem < r_b), "remainder not below divisor")
    `EGU_ASSERT(a_exclusive, i_clk, i_rst_n, $onehot0({i_cmd.load, i_cmd.div_start, i_cmd.div_step, i_cmd.update}), "commands overlap")
    `EGU_ASSERT(a_start_nz, i_clk, i_rst_n, i_cmd.div_start |-> !o_status.b_zero, "division by zero")
endmodule

[design/extended_gcd_unit.sv]
// Top level of the extended gcd unit: stream ports around controller and datapath.
// Depends on egu_pkg, egu_ctrl and egu_datapath.
// One item at a time: it is taken when ready is high, then each Euclid step runs one check,
// WIDTH bit-serial division steps with the products formed alongside, and one update. The
// result stays on the output until taken, and ready is low meanwhile; the next input can be
// taken in the cycle after the result is taken.
module extended_gcd_unit #(
    parameter int unsigned WIDTH = egu_pkg::DefWidth
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_value [31:0], b_value [63:32]
    input  logic [egu_pkg::InDataW-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // gcd_value [31:0], coef_a [64:32], coef_b [97:65], zeros above
    output logic [egu_pkg::OutDataW-1:0]     m_axis_tdata
);
    import egu_pkg::*;

    t_egu_cmd    w_cmd;
    t_egu_status w_status;
    logic [WIDTH-1:0] w_gcd;
    logic [WIDTH:0]   w_x, w_y;

    egu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    egu_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_a(s_axis_tdata[WIDTH-1:0]), .i_b(s_axis_tdata[GcdW +: WIDTH]),
        .o_status(w_status), .o_gcd(w_gcd), .o_x(w_x), .o_y(w_y)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[GcdW-1:0] = GcdW'(w_gcd);
        m_axis_tdata[GcdW +: CoefW] = CoefW'(signed'(w_x));
        m_axis_tdata[GcdW+CoefW +: CoefW] = CoefW'(signed'(w_y));
    end
endmodule

[tb/sv/tb.sv]
// Testbench of the extended gcd unit: drives operand pairs over the input stream and checks
// gcd and Bezout coefficients against an in-bench predictor held in a small scoreboard class.
// Depends on egu_pkg and extended_gcd_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import egu_pkg::*;

    typedef struct packed {
        logic [CoefW-1:0] coef_b;
        logic [CoefW-1:0] coef_a;
        logic [GcdW-1:0]  gcd_value;
    } t_bezout;

    class bezout_board;
        t_bezout pending[$];
        int      errors = 0;

        function t_bezout solve_bezout(logic [31:0] a_in, logic [31:0] b_in);
            logic [63:0] a, b, q, r, tx, ty, cx, cy, nx, ny;
            t_bezout res;
            a = a_in; b = b_in;
            cx = 1; cy = 0; nx = 0; ny = 1;
            while (b != 0) begin
                q = a / b;
                r = a % b;
                a = b;
                b = r;
                tx = cx - q * nx; cx = nx; nx = tx;
                ty = cy - q * ny; cy = ny; ny = ty;
            end
            res.gcd_value = a[GcdW-1:0];
            res.coef_a = cx[CoefW-1:0];
            res.coef_b = cy[CoefW-1:0];
            return res;
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending.push_back(solve_bezout(a, b));
        endfunction

        function void check_result(logic [OutDataW-1:0] data);
            t_bezout exp_r, got;
            got = data[$bits(t_bezout)-1:0];
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.gcd_value !== exp_r.gcd_value) begin
                $error("gcd_value expected %h actual %h", exp_r.gcd_value, got.gcd_value);
                errors++;
            end
            if (got.coef_a !== exp_r.coef_a) begin
                $error("coef_a expected %h actual %h", exp_r.coef_a, got.coef_a);
                errors++;
            end
            if (got.coef_b !== exp_r.coef_b) begin
                $error("coef_b expected %h actual %h", exp_r.coef_b, got.coef_b);
                errors++;
            end
            if (data[OutDataW-1:$bits(t_bezout)] !== '0) begin
                $error("padding expected 0 actual %h", data[OutDataW-1:$bits(t_bezout)]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [InDataW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;

    bezout_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    extended_gcd_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 40000) begin
            $display("extended_gcd_unit test failed");
            $finish;
        end
    end

    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_operands(a, b);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom_range(255);
            1: return $urandom_range(65535);
            2: return 32'hFFFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a, b, g;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_pair(0, 0);
        send_pair(32'hFFFF_FFFF, 0);
        send_pair(0, 32'hFFFF_FFFF);
        send_pair(0, 7);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(1, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 1);
        send_pair(2971215073, 1836311903);
        send_pair(1836311903, 2971215073);
        send_pair(32'h8000_0000, 32'h4000_0000);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(12, 18);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 36) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 64 : 36) : 0;
            for (int n = 0; n < 85; n++) begin
                a = pick_operand();
                b = pick_operand();
                if ($urandom_range(3) == 0) begin
                    g = $urandom_range(1, 1000);
                    a = (a % 4000000) * g;
                    b = (b % 4000000) * g;
                end
                send_pair(a, b);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("extended_gcd_unit test passed");
        end else begin
            $display("extended_gcd_unit test failed");
        end
        $finish;
    end
endmodule
